>>> rtl/asdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdt_pkg
// Types and constants shared by the single data transfer unit: request and
// result payloads, the decoded operation queued between front and back, and
// the peripheral address map.
// ----------------------------------------------------------------------------
package asdt_pkg;

    // Command codes
    typedef enum logic {
        CMD_EXECUTE = 1'b0,
        CMD_PRELOAD = 1'b1
    } asdt_cmd_t;

    // Shift kinds for a register offset
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } asdt_shift_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MEMORY        = 3'd0,
        ST_GPIO0         = 3'd1,
        ST_GPIO1         = 3'd2,
        ST_GPIO2         = 3'd3,
        ST_LED_OFF       = 3'd4,
        ST_LED_ON        = 3'd5,
        ST_OUT_OF_BOUNDS = 3'd6
    } asdt_status_t;

    // Peripheral address map
    localparam logic [31:0] GPIO_BANK0_ADDR = 32'h2020_0000;
    localparam logic [31:0] GPIO_BANK1_ADDR = 32'h2020_0004;
    localparam logic [31:0] GPIO_BANK2_ADDR = 32'h2020_0008;
    localparam logic [31:0] LED_OFF_ADDR    = 32'h2020_0028;
    localparam logic [31:0] LED_ON_ADDR     = 32'h2020_001c;

    // Instruction bit positions
    localparam int BIT_I = 25;
    localparam int BIT_P = 24;
    localparam int BIT_U = 23;
    localparam int BIT_L = 20;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Byte lanes of the data memory
    localparam int LANES = 4;

    // Input request
    typedef struct packed {
        logic        cmd;
        logic [31:0] instruction;
        logic [31:0] base_value;
        logic [31:0] rm_value;
        logic [31:0] rd_value;
        logic [15:0] preload_address;
        logic [31:0] preload_word;
    } asdt_req_t;

    // Output result
    typedef struct packed {
        logic        dest_write;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic        base_write;
        logic [3:0]  base_index;
        logic [31:0] base_new;
        logic [31:0] effective_address;
        logic [2:0]  status;
    } asdt_res_t;

    // Front stage: request with offset already formed
    typedef struct packed {
        logic        is_preload;
        logic        is_load;
        logic        pre_index;
        logic        add_offset;
        logic [3:0]  rn;
        logic [3:0]  rd;
        logic [31:0] base;
        logic [31:0] offset;
        logic [31:0] wdata;
    } asdt_fe_t;

    // Classified operation handed to the back end
    typedef struct packed {
        logic         is_preload;
        logic         is_load;
        logic         access;
        logic         gpio_load;
        logic         base_write;
        logic [3:0]   dest_index;
        logic [3:0]   base_index;
        logic [31:0]  base_new;
        logic [31:0]  addr;
        asdt_status_t status;
        logic [31:0]  wdata;
    } asdt_op_t;

endpackage

>>> rtl/asdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdt_front
// Accepts requests, forms the offset, then computes the address and
// classifies the access (memory, GPIO, LED, out of bounds) into the queue.
// ----------------------------------------------------------------------------
module asdt_front
    import asdt_pkg::*;
#(
    parameter int MEMORY_BYTES = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  asdt_req_t request,
    input  logic      full,
    input  logic      clearing,
    output logic      busy,
    output logic      push,
    output asdt_op_t  push_data
);

    // Highest byte address at which a whole word still fits
    localparam logic [31:0] LAST_WORD_ADDR = 32'(MEMORY_BYTES - 4);

    logic        valid_reg, valid_next;
    asdt_fe_t    fe_reg, fe_next;
    logic        accept;
    logic [31:0] shifted;
    logic [4:0]  amount;
    logic [63:0] doubled;

    assign busy   = clearing | (valid_reg & full);
    assign accept = start & ~busy;
    assign push   = valid_reg & ~full;

    // Register offset: Rm shifted by a constant amount
    always_comb
    begin
        amount  = request.instruction[11:7];
        doubled = {request.rm_value, request.rm_value} >> amount;
        case (asdt_shift_t'(request.instruction[6:5]))
            SH_LSL:  shifted = request.rm_value << amount;
            SH_LSR:  shifted = request.rm_value >> amount;
            SH_ASR:  shifted = 32'($signed(request.rm_value) >>> amount);
            SH_ROR:  shifted = doubled[31:0];
            default: shifted = request.rm_value;
        endcase
    end

    // Stage contents; a preload rides as a pre-indexed access at its address
    always_comb
    begin
        fe_next.rn = request.instruction[19:16];
        fe_next.rd = request.instruction[15:12];
        if (request.cmd == CMD_PRELOAD)
        begin
            fe_next.is_preload = 1'b1;
            fe_next.is_load    = 1'b0;
            fe_next.pre_index  = 1'b1;
            fe_next.add_offset = 1'b1;
            fe_next.base       = {16'd0, request.preload_address};
            fe_next.offset     = 32'd0;
            fe_next.wdata      = request.preload_word;
        end
        else
        begin
            fe_next.is_preload = 1'b0;
            fe_next.is_load    = request.instruction[BIT_L];
            fe_next.pre_index  = request.instruction[BIT_P];
            fe_next.add_offset = request.instruction[BIT_U];
            fe_next.base       = request.base_value;
            fe_next.offset     = request.instruction[BIT_I] ? shifted
                                                            : {20'd0, request.instruction[11:0]};
            fe_next.wdata      = request.rd_value;
        end
        valid_next = accept ? 1'b1 : (push ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fe_reg <= fe_next;
        end
    end

    // Address and classification
    always_comb
    begin
        logic [31:0] moved;
        logic [31:0] addr;
        logic        fits;
        logic        gpio;

        moved = fe_reg.add_offset ? fe_reg.base + fe_reg.offset
                                  : fe_reg.base - fe_reg.offset;
        addr  = fe_reg.pre_index ? moved : fe_reg.base;
        fits  = addr <= LAST_WORD_ADDR;
        gpio  = (addr == GPIO_BANK0_ADDR) || (addr == GPIO_BANK1_ADDR)
             || (addr == GPIO_BANK2_ADDR);

        push_data.is_preload = fe_reg.is_preload;
        push_data.is_load    = fe_reg.is_load;
        push_data.access     = fits;
        push_data.gpio_load  = ~fits & gpio & fe_reg.is_load;
        push_data.base_write = ~fe_reg.pre_index;
        push_data.dest_index = fe_reg.rd;
        push_data.base_index = fe_reg.rn;
        push_data.base_new   = moved;
        push_data.addr       = addr;
        push_data.wdata      = fe_reg.wdata;

        if (fits)
            push_data.status = ST_MEMORY;
        else if (addr == GPIO_BANK0_ADDR)
            push_data.status = ST_GPIO0;
        else if (addr == GPIO_BANK1_ADDR)
            push_data.status = ST_GPIO1;
        else if (addr == GPIO_BANK2_ADDR)
            push_data.status = ST_GPIO2;
        else if (!fe_reg.is_load && addr == LED_OFF_ADDR)
            push_data.status = ST_LED_OFF;
        else if (!fe_reg.is_load && addr == LED_ON_ADDR)
            push_data.status = ST_LED_ON;
        else
            push_data.status = ST_OUT_OF_BOUNDS;
    end

endmodule

>>> rtl/asdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdt_queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module asdt_queue
    import asdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  asdt_op_t push_data,
    input  logic     pop,
    output asdt_op_t pop_data,
    output logic     full,
    output logic     empty
);

    asdt_op_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/asdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdt_back
// Carries out queued operations against a byte memory split into four
// byte lanes, so an unaligned word is one row access per lane. Clears the
// memory row by row after reset and builds the result.
// ----------------------------------------------------------------------------
module asdt_back
    import asdt_pkg::*;
#(
    parameter int MEMORY_BYTES = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  asdt_op_t  op,
    output logic      clearing,
    output logic      done,
    output asdt_res_t result
);

    localparam int ROWS  = (MEMORY_BYTES + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic             clear_active_reg, clear_active_next;
    logic [ROW_W-1:0] clear_row_reg, clear_row_next;

    logic             lane_we    [LANES];
    logic             lane_re    [LANES];
    logic [ROW_W-1:0] lane_row   [LANES];
    logic [7:0]       lane_wbyte [LANES];
    logic [7:0]       lane_rdata [LANES];

    logic             res_valid_reg;
    asdt_op_t         res_op_reg;
    logic [31:0]      load_word;
    logic             mem_load;
    logic             mem_write;
    logic [1:0]       lead;

    assign clearing = clear_active_reg;

    // Clearing pass over all rows after reset
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_row_next    = clear_row_reg;
        if (clear_active_reg)
        begin
            if (clear_row_reg == ROW_W'(ROWS - 1))
                clear_active_next = 1'b0;
            else
                clear_row_next = clear_row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_row_reg    <= '0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_row_reg    <= clear_row_next;
        end
    end

    // Lane steering: byte i of the word sits in lane (addr + i) mod 4
    always_comb
    begin
        logic [1:0] sel;

        sel       = '0;
        lead      = op.addr[1:0];
        mem_write = op_valid & op.access & ~op.is_load;
        mem_load  = op_valid & op.access & op.is_load;
        for (int k = 0; k < LANES; k++)
        begin
            sel = 2'(k) - lead;
            if (clear_active_reg)
            begin
                lane_we[k]    = 1'b1;
                lane_re[k]    = 1'b0;
                lane_row[k]   = clear_row_reg;
                lane_wbyte[k] = 8'd0;
            end
            else
            begin
                lane_we[k]    = mem_write;
                lane_re[k]    = mem_load;
                lane_row[k]   = op.addr[ROW_W+1:2] + ROW_W'(2'(k) < lead);
                lane_wbyte[k] = op.wdata[{sel, 3'b000} +: 8];
            end
        end
    end

    // Byte lane memories with registered read
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic [7:0] mem [ROWS];
        logic [7:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (lane_we[k])
            begin
                mem[lane_row[k]] <= lane_wbyte[k];
            end
            if (lane_re[k])
            begin
                rdata_reg <= mem[lane_row[k]];
            end
        end

        assign lane_rdata[k] = rdata_reg;
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= op_valid & ~op.is_preload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid)
        begin
            res_op_reg <= op;
        end
    end

    // Reassemble the little-endian word from the lanes
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            load_word[8*i +: 8] = lane_rdata[2'(i) + res_op_reg.addr[1:0]];
        end
    end

    always_comb
    begin
        logic from_mem;

        from_mem                 = res_op_reg.access & res_op_reg.is_load;
        done                     = res_valid_reg;
        result.dest_write        = from_mem | res_op_reg.gpio_load;
        result.dest_index        = res_op_reg.dest_index;
        result.dest_value        = from_mem ? load_word
                                 : (res_op_reg.gpio_load ? res_op_reg.addr : 32'd0);
        result.base_write        = res_op_reg.base_write;
        result.base_index        = res_op_reg.base_index;
        result.base_new          = res_op_reg.base_new;
        result.effective_address = res_op_reg.addr;
        result.status            = res_op_reg.status;
    end

endmodule

>>> rtl/arm_single_data_transfer_unit.sv
`timescale 1ns / 1ps
// Result path: an accepted execute request passes the front register, a
// queue entry and the result stage, whose strobe is done; preloads give
// no result. Throughput: one request per cycle while busy is low, set by
// the single-port byte lanes. Reset: asynchronous, active low; afterwards
// busy is high while ceil(MEMORY_BYTES/4) rows (16384 by default) clear.
// ----------------------------------------------------------------------------
// arm_single_data_transfer_unit
// Word LDR/STR unit over a little-endian byte memory with GPIO and LED
// address decode. Front end decodes, a short queue decouples, back end
// performs the access.
// ----------------------------------------------------------------------------
module arm_single_data_transfer_unit
    import asdt_pkg::*;
#(
    parameter int MEMORY_BYTES = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  asdt_req_t request,
    output logic      busy,
    output logic      done,
    output asdt_res_t result
);

    logic     q_push;
    asdt_op_t q_push_data;
    logic     q_full;
    logic     q_empty;
    asdt_op_t q_pop_data;
    logic     clearing;

    // Decode and classify
    asdt_front #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .full      (q_full),
        .clearing  (clearing),
        .busy      (busy),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Decoupling queue
    asdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (~q_empty),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Memory access and result
    asdt_back #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (~q_empty),
        .op       (q_pop_data),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

`ifndef SYNTHESIS
    // No result while the memory is being cleared
    a_no_done_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done)
        else $error("result issued during memory clear");

    // Execute request yields its result at fixed latency
    a_execute_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == CMD_EXECUTE) |=> ##2 done)
        else $error("execute request lost or late");

    // Preload takes a slot but gives no result
    a_preload_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == CMD_PRELOAD) |=> ##2 !done)
        else $error("preload produced a result");

    // Out-of-bounds access never writes Rd, and no write means zero data
    a_dest_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!(result.dest_write && result.status == 3'(ST_OUT_OF_BOUNDS))
                  && (result.dest_write || result.dest_value == 32'd0)))
        else $error("inconsistent destination write");
`endif

endmodule

>>> verif/tb_arm_single_data_transfer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_single_data_transfer_unit
// Self-checking bench for the word LDR/STR unit. A queue of requests, directed
// corner cases first and then random well-formed transfers, preloads and raw
// noise, feeds a driver that idles at random. A transfer predictor with its
// own byte memory image computes each expected result when a request is
// accepted, and a monitor compares every strobed result field by field.
// ----------------------------------------------------------------------------
module tb_arm_single_data_transfer_unit;
    import asdt_pkg::*;

    localparam int MEM_BYTES       = 65536;
    localparam int MEM_AW          = $clog2(MEM_BYTES);
    localparam int RANDOM_ITEMS    = 500;
    localparam int DRAIN_AT        = 250;
    localparam int TAIL_CYCLES     = 10;
    localparam int WATCHDOG_CYCLES = 80000;
    localparam int MAX_PRINTED     = 50;

    // Request waiting in the stimulus queue
    typedef struct {
        asdt_req_t   req;
        int unsigned gap;
        bit          drain;
    } queued_req_t;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    asdt_req_t request = '0;
    logic      busy;
    logic      done;
    asdt_res_t result;

    queued_req_t queued_requests[$];
    asdt_res_t   expected_results[$];
    logic [7:0]  mem_image [MEM_BYTES];

    bit          req_taken;
    bit          gap_loaded;
    bit          drain_next;
    int unsigned gap_left;
    int unsigned quiet_left;
    int unsigned idle_cycles;
    int unsigned errors;
    int unsigned executes_taken;
    int unsigned preloads_taken;
    int unsigned results_checked;
    int unsigned status_hits [7];

    arm_single_data_transfer_unit #(
        .MEMORY_BYTES(MEM_BYTES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Transfer predictor
    // ------------------------------------------------------------------

    // Whole word inside memory, no wrap
    function automatic bit fits_word(input logic [31:0] a);
        return (64'(a) + 64'd3) < 64'(MEM_BYTES);
    endfunction

    function automatic void store_word(input logic [31:0] a, input logic [31:0] w);
        mem_image[MEM_AW'(a)]     = w[7:0];
        mem_image[MEM_AW'(a + 1)] = w[15:8];
        mem_image[MEM_AW'(a + 2)] = w[23:16];
        mem_image[MEM_AW'(a + 3)] = w[31:24];
    endfunction

    // Immediate or constant-shifted Rm offset
    function automatic logic [31:0] operand_offset(input logic [31:0] ins,
                                                   input logic [31:0] rm);
        logic [4:0] amt;
        amt = ins[11:7];
        if (!ins[BIT_I])
            return {20'b0, ins[11:0]};
        if (amt == 5'd0)
            return rm;
        case (asdt_shift_t'(ins[6:5]))
            SH_LSL:  return rm << amt;
            SH_LSR:  return rm >> amt;
            SH_ASR:  return $unsigned($signed(rm) >>> amt);
            default: return (rm >> amt) | (rm << (6'd32 - {1'b0, amt}));
        endcase
    endfunction

    // Applies one request to the memory image; returns 1 when a result is due
    function automatic bit transfer_outcome(input asdt_req_t rq, output asdt_res_t rs);
        logic [31:0] ins;
        logic [31:0] offset;
        logic [31:0] moved;
        logic [31:0] addr;
        logic        is_load;
        ins = rq.instruction;
        rs  = '0;
        if (rq.cmd == CMD_PRELOAD)
        begin
            if (fits_word({16'b0, rq.preload_address}))
                store_word({16'b0, rq.preload_address}, rq.preload_word);
            return 1'b0;
        end
        is_load = ins[BIT_L];
        offset  = operand_offset(ins, rq.rm_value);
        moved   = ins[BIT_U] ? rq.base_value + offset : rq.base_value - offset;
        addr    = ins[BIT_P] ? moved : rq.base_value;

        rs.dest_index        = ins[15:12];
        rs.base_write        = !ins[BIT_P];
        rs.base_index        = ins[19:16];
        rs.base_new          = moved;
        rs.effective_address = addr;
        if (fits_word(addr))
        begin
            rs.status = ST_MEMORY;
            if (is_load)
            begin
                rs.dest_write = 1'b1;
                rs.dest_value = {mem_image[MEM_AW'(addr + 3)], mem_image[MEM_AW'(addr + 2)],
                                 mem_image[MEM_AW'(addr + 1)], mem_image[MEM_AW'(addr)]};
            end
            else
                store_word(addr, rq.rd_value);
        end
        else if (addr == GPIO_BANK0_ADDR || addr == GPIO_BANK1_ADDR
                 || addr == GPIO_BANK2_ADDR)
        begin
            rs.status = (addr == GPIO_BANK0_ADDR) ? ST_GPIO0 :
                        (addr == GPIO_BANK1_ADDR) ? ST_GPIO1 : ST_GPIO2;
            // GPIO load hands back the address itself
            rs.dest_write = is_load;
            rs.dest_value = is_load ? addr : 32'd0;
        end
        else if (!is_load && addr == LED_OFF_ADDR)
            rs.status = ST_LED_OFF;
        else if (!is_load && addr == LED_ON_ADDR)
            rs.status = ST_LED_ON;
        else
            rs.status = ST_OUT_OF_BOUNDS;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
                     $realtime, what, got, want);
    endtask

    task automatic check_result(input asdt_res_t got, input asdt_res_t want);
        if (got.dest_write !== want.dest_write)
            report_mismatch("dest_write", 32'(got.dest_write), 32'(want.dest_write));
        if (got.dest_index !== want.dest_index)
            report_mismatch("dest_index", 32'(got.dest_index), 32'(want.dest_index));
        if (got.dest_value !== want.dest_value)
            report_mismatch("dest_value", got.dest_value, want.dest_value);
        if (got.base_write !== want.base_write)
            report_mismatch("base_write", 32'(got.base_write), 32'(want.base_write));
        if (got.base_index !== want.base_index)
            report_mismatch("base_index", 32'(got.base_index), 32'(want.base_index));
        if (got.base_new !== want.base_new)
            report_mismatch("base_new", got.base_new, want.base_new);
        if (got.effective_address !== want.effective_address)
            report_mismatch("effective_address", got.effective_address,
                            want.effective_address);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic asdt_req_t random_request();
        asdt_req_t rq;
        rq.cmd             = 1'($urandom());
        rq.instruction     = $urandom();
        rq.base_value      = $urandom();
        rq.rm_value        = $urandom();
        rq.rd_value        = $urandom();
        rq.preload_address = 16'($urandom());
        rq.preload_word    = $urandom();
        return rq;
    endfunction

    // Transfer word; condition, B, W and bits 27-26 stay random
    function automatic logic [31:0] ldr_str(input bit reg_form, input bit pre,
                                            input bit up, input bit load,
                                            input logic [3:0] rn, input logic [3:0] rd,
                                            input logic [11:0] operand);
        logic [31:0] ins;
        ins        = $urandom();
        ins[BIT_I] = reg_form;
        ins[BIT_P] = pre;
        ins[BIT_U] = up;
        ins[BIT_L] = load;
        ins[19:16] = rn;
        ins[15:12] = rd;
        ins[11:0]  = operand;
        return ins;
    endfunction

    // Shift amount and kind; bit 4 and Rm number random
    function automatic logic [11:0] shift_field(input logic [4:0] amt,
                                                input asdt_shift_t kind);
        return {amt, kind, 5'($urandom())};
    endfunction

    // Base value that makes the access land on target
    function automatic logic [31:0] base_for(input logic [31:0] ins, input logic [31:0] rm,
                                             input logic [31:0] target);
        logic [31:0] offset;
        offset = operand_offset(ins, rm);
        if (!ins[BIT_P])
            return target;
        return ins[BIT_U] ? target - offset : target + offset;
    endfunction

    function automatic logic [31:0] pick_target();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 95);
        if (r < 55)
            return MEM_BYTES - 4 - $urandom_range(0, 63);
        if (r < 70)
            return $urandom_range(0, MEM_BYTES - 4);
        if (r < 80)
            case ($urandom_range(0, 4))
                0:       return GPIO_BANK0_ADDR;
                1:       return GPIO_BANK1_ADDR;
                2:       return GPIO_BANK2_ADDR;
                3:       return LED_OFF_ADDR;
                default: return LED_ON_ADDR;
            endcase
        if (r < 90)
            return MEM_BYTES - 3 + $urandom_range(0, 2);
        if (r < 95)
            return GPIO_BANK0_ADDR + $urandom_range(0, 63);
        return $urandom();
    endfunction

    function automatic logic [15:0] pick_preload_address();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 16'($urandom_range(0, 95));
        if (r < 75)
            return 16'(MEM_BYTES - 4 - $urandom_range(0, 63));
        if (r < 90)
            return 16'($urandom_range(0, MEM_BYTES - 4));
        return 16'(MEM_BYTES - 3 + $urandom_range(0, 2));
    endfunction

    // Queue a request with its idle gap; gap-free bursts now and then
    task automatic add_item(input asdt_req_t rq);
        queued_req_t it;
        it.req   = rq;
        it.drain = drain_next;
        drain_next = 1'b0;
        if (quiet_left > 0)
        begin
            quiet_left--;
            it.gap = 0;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            quiet_left = $urandom_range(8, 40);
            it.gap     = 0;
        end
        else
            it.gap = $urandom_range(0, 10);
        queued_requests.push_back(it);
    endtask

    task automatic add_exec(input logic [31:0] ins, input logic [31:0] base,
                            input logic [31:0] rm, input logic [31:0] rd);
        asdt_req_t rq;
        rq             = random_request();
        rq.cmd         = CMD_EXECUTE;
        rq.instruction = ins;
        rq.base_value  = base;
        rq.rm_value    = rm;
        rq.rd_value    = rd;
        add_item(rq);
    endtask

    task automatic add_preload(input logic [15:0] addr, input logic [31:0] word);
        asdt_req_t rq;
        rq                 = random_request();
        rq.cmd             = CMD_PRELOAD;
        rq.preload_address = addr;
        rq.preload_word    = word;
        add_item(rq);
    endtask

    // ------------------------------------------------------------------
    // Driver: falling edge, one request in flight on the port
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive
        queued_req_t nxt;
        logic        nstart;
        nstart = start;
        if (!rst_n)
            nstart = 1'b0;
        else if (!start || req_taken)
        begin
            nstart = 1'b0;
            if (queued_requests.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = queued_requests[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!(queued_requests[0].drain && expected_results.size() != 0))
                begin
                    nxt        = queued_requests.pop_front();
                    request   <= nxt.req;
                    nstart     = 1'b1;
                    gap_loaded = 1'b0;
                end
            end
        end
        start <= nstart;
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge, results first, then the accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        asdt_res_t want;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with none pending, address",
                                    result.effective_address, 32'd0);
                else
                begin
                    check_result(result, expected_results.pop_front());
                    results_checked++;
                end
            end

            req_taken <= start && !busy;
            if (start && !busy)
            begin
                if (transfer_outcome(request, want))
                begin
                    expected_results.push_back(want);
                    status_hits[want.status]++;
                    executes_taken++;
                end
                else
                    preloads_taken++;
            end

            // Watchdog on cycles with no handshake at all
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Watchdog: no request or result for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] ins;
        logic [31:0] rm;
        logic [4:0]  amt;
        int unsigned r;

        foreach (mem_image[i])
            mem_image[i] = 8'd0;

        // Preloads: first and last word that fit, one that runs off the end
        add_preload(16'd0, 32'h1122_3344);
        add_preload(16'(MEM_BYTES - 4), 32'hcafe_f00d);
        add_preload(16'hffff, 32'hdead_beef);

        // Immediate offsets: aligned, unaligned, top word, first word past the end
        ins = ldr_str(1'b0, 1'b1, 1'b1, 1'b1, 4'd1, 4'd2, 12'd0);
        add_exec(ins, 32'd0, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b1, 1'b1, 1'b1, 4'd1, 4'd3, 12'd1);
        add_exec(ins, 32'd0, $urandom(), $urandom());
        rm  = $urandom();
        ins = ldr_str(1'b0, 1'b1, 1'b1, 1'b1, 4'd2, 4'd4, 12'hfff);
        add_exec(ins, base_for(ins, rm, MEM_BYTES - 4), rm, $urandom());
        ins = ldr_str(1'b0, 1'b1, 1'b1, 1'b1, 4'd6, 4'd7, 12'd0);
        add_exec(ins, MEM_BYTES - 3, $urandom(), $urandom());

        // Post-index store, then post-index load where Rn and Rd coincide
        ins = ldr_str(1'b0, 1'b0, 1'b0, 1'b0, 4'd3, 4'd4, 12'd4);
        add_exec(ins, 32'd100, $urandom(), 32'hffff_ffff);
        ins = ldr_str(1'b0, 1'b0, 1'b1, 1'b1, 4'd5, 4'd5, 12'hfff);
        add_exec(ins, 32'd100, $urandom(), $urandom());

        // Address wraps below zero; writeback wraps above the top
        ins = ldr_str(1'b0, 1'b1, 1'b0, 1'b1, 4'd8, 4'd9, 12'hfff);
        add_exec(ins, 32'd0, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b0, 1'b1, 1'b1, 4'd15, 4'd14, 12'hfff);
        add_exec(ins, 32'hffff_ffff, $urandom(), $urandom());

        // Zero shift amount with every kind passes Rm through
        for (int k = 0; k < 4; k++)
        begin
            ins = ldr_str(1'b1, 1'b1, 1'b1, 1'b1, 4'(k), 4'(k + 4),
                          shift_field(5'd0, asdt_shift_t'(k)));
            add_exec(ins, 32'd0, 32'(8 * k + 1), $urandom());
        end

        // Widest shifts but ROR by one; Rm negative so ASR fills with ones
        for (int k = 0; k < 4; k++)
        begin
            amt = (asdt_shift_t'(k) == SH_ROR) ? 5'd1 : 5'd31;
            rm  = $urandom() | 32'h8000_0000;
            ins = ldr_str(1'b1, 1'b1, 1'(k), 1'(k >> 1), 4'(k + 8), 4'(k + 1),
                          shift_field(amt, asdt_shift_t'(k)));
            add_exec(ins, base_for(ins, rm, 32'(16 * k)), rm, $urandom());
        end

        // GPIO loads and store, LED stores, load from an LED address
        ins = ldr_str(1'b0, 1'b0, 1'b1, 1'b1, 4'd1, 4'd2, 12'($urandom()));
        add_exec(ins, GPIO_BANK0_ADDR, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b0, 1'b0, 1'b1, 4'd3, 4'd4, 12'($urandom()));
        add_exec(ins, GPIO_BANK1_ADDR, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b0, 1'b1, 1'b0, 4'd5, 4'd6, 12'($urandom()));
        add_exec(ins, GPIO_BANK2_ADDR, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b0, 1'b1, 1'b0, 4'd7, 4'd8, 12'($urandom()));
        add_exec(ins, LED_OFF_ADDR, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b0, 1'b0, 1'b0, 4'd9, 4'd10, 12'($urandom()));
        add_exec(ins, LED_ON_ADDR, $urandom(), $urandom());
        ins = ldr_str(1'b0, 1'b0, 1'b1, 1'b1, 4'd11, 4'd12, 12'($urandom()));
        add_exec(ins, LED_ON_ADDR, $urandom(), $urandom());

        // Random part: mostly well-formed transfers around hot addresses
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (n == DRAIN_AT)
                drain_next = 1'b1;
            if (r < 15)
                add_preload(pick_preload_address(), $urandom());
            else if (r < 90)
            begin
                rm  = $urandom();
                amt = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom());
                if ($urandom_range(0, 1))
                    ins = ldr_str(1'b1, 1'($urandom()), 1'($urandom()), 1'($urandom()),
                                  4'($urandom()), 4'($urandom()),
                                  shift_field(amt, asdt_shift_t'($urandom_range(0, 3))));
                else
                    ins = ldr_str(1'b0, 1'($urandom()), 1'($urandom()), 1'($urandom()),
                                  4'($urandom()), 4'($urandom()), 12'($urandom()));
                add_exec(ins, base_for(ins, rm, pick_target()), rm, $urandom());
            end
            else
                add_item(random_request());
        end

        // Single reset; the block clears its memory before it takes requests
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d transfers and %0d preloads; %0d results checked.",
                 executes_taken, preloads_taken, results_checked);
        $display("Status mix: memory %0d, gpio %0d/%0d/%0d, led off %0d, led on %0d, oob %0d",
                 status_hits[ST_MEMORY], status_hits[ST_GPIO0], status_hits[ST_GPIO1],
                 status_hits[ST_GPIO2], status_hits[ST_LED_OFF], status_hits[ST_LED_ON],
                 status_hits[ST_OUT_OF_BOUNDS]);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
